// File: rtl/core/ssr_pkg.sv
// ----------------------------------------------------------------------------
// ssr_pkg
// Shared types and constants for the streaming substring replace core.
// ----------------------------------------------------------------------------
package ssr_pkg;

   localparam int BYTE_W    = 8;
   localparam int BUF_DEPTH = 8;             // pending bytes, also max pattern length
   localparam int IDX_W     = 3;             // index into pending buffer / replacement
   localparam int CNT_W     = 4;             // pending count, holds 0..BUF_DEPTH
   localparam int LEN_W     = 4;
   localparam int TEXT_W    = 64;
   localparam int CSR_IDX_W = 2;

   localparam logic [LEN_W-1:0] PAT_MAX = 4'd8;
   localparam logic [LEN_W-1:0] REP_MAX = 4'd8;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_BYTES      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LENGTH     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLACEMENT_BYTES  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLACEMENT_LENGTH = 2'd3;

   typedef struct packed {
      logic [BYTE_W-1:0] text_byte;
      logic              line_end;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              run_last;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;        // load input word into pending buffer
      logic emit_pending;  // emit oldest pending byte and shift
      logic start_repl;    // full match: drop pending, rewind replacement index
      logic emit_repl;     // emit next replacement byte
      logic finish;        // push staged byte out as the final word of this item
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic prefix_ok;     // pending bytes are a prefix of the pattern
      logic full_match;    // ... and as long as the pattern
      logic pend_empty;
      logic pend_one;
      logic repl_none;     // replacement length is zero
      logic repl_done;     // current replacement byte is the last one
      logic line_last;     // item carried line_end
      logic stage_valid;   // a byte waits in the staging register
      logic emit_ok;       // staging register may take a new byte
   } status_type;

endpackage

// File: rtl/core/ssr_datapath.sv
// ----------------------------------------------------------------------------
// ssr_datapath
// Config registers, pending buffer, replacement index, one-word staging
// register and the output register.
// ----------------------------------------------------------------------------
module ssr_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  ssr_pkg::req_type                  req_data,
   output ssr_pkg::rsp_type                  rsp_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic                              csr_we,
   input  logic [ssr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ssr_pkg::TEXT_W-1:0]        csr_wdata,
   input  ssr_pkg::cmd_type                  cmd,
   output ssr_pkg::status_type               status
);
   import ssr_pkg::*;

   logic [TEXT_W-1:0] pat_bytes_ff, pat_bytes_in;
   logic [LEN_W-1:0]  pat_len_ff,   pat_len_in;
   logic [TEXT_W-1:0] rep_bytes_ff, rep_bytes_in;
   logic [LEN_W-1:0]  rep_len_ff,   rep_len_in;

   logic [BYTE_W-1:0] pend_buf_ff [BUF_DEPTH];
   logic [BYTE_W-1:0] pend_buf_in [BUF_DEPTH];
   logic [CNT_W-1:0]  pend_cnt_ff,  pend_cnt_in;
   logic              line_last_ff, line_last_in;
   logic [IDX_W-1:0]  rep_idx_ff,   rep_idx_in;

   logic [BYTE_W-1:0] stage_byte_ff, stage_byte_in;
   logic              stage_valid_ff, stage_valid_in;
   rsp_type           out_ff, out_in;
   logic              out_valid_ff, out_valid_in;

   logic [LEN_W-1:0]     plen, rlen;
   logic [BUF_DEPTH-1:0] byte_ok;
   logic                 prefix_ok;
   logic                 slot_free;
   logic                 emit;
   logic                 push;
   logic [BYTE_W-1:0]    emit_byte;
   logic [IDX_W-1:0]     wr_idx;
   logic                 pat_write;

   // effective lengths
   always_comb begin
      if (pat_len_ff == '0) begin
         plen = LEN_W'(1);
      end else if (pat_len_ff > PAT_MAX) begin
         plen = PAT_MAX;
      end else begin
         plen = pat_len_ff;
      end
      rlen = (rep_len_ff > REP_MAX) ? REP_MAX : rep_len_ff;
   end

   always_comb begin
      for (int k = 0; k < BUF_DEPTH; k++) begin
         byte_ok[k] = (CNT_W'(k) >= pend_cnt_ff) ||
                      (pend_buf_ff[k] == pat_bytes_ff[k*BYTE_W +: BYTE_W]);
      end
   end
   assign prefix_ok = &byte_ok;

   assign slot_free = !out_valid_ff || rsp_ready;
   assign emit      = cmd.emit_pending || cmd.emit_repl;
   assign push      = (emit || cmd.finish) && stage_valid_ff;
   assign emit_byte = cmd.emit_repl ? rep_bytes_ff[rep_idx_ff*BYTE_W +: BYTE_W]
                                    : pend_buf_ff[0];
   // a leftover full count (never expected) restarts the buffer
   assign wr_idx    = (pend_cnt_ff >= plen) ? '0 : pend_cnt_ff[IDX_W-1:0];
   assign pat_write = csr_we && ((csr_index == CSR_PATTERN_BYTES) ||
                                 (csr_index == CSR_PATTERN_LENGTH));

   always_comb begin
      pat_bytes_in = pat_bytes_ff;
      pat_len_in   = pat_len_ff;
      rep_bytes_in = rep_bytes_ff;
      rep_len_in   = rep_len_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_PATTERN_BYTES:      pat_bytes_in = csr_wdata;
            CSR_PATTERN_LENGTH:     pat_len_in   = csr_wdata[LEN_W-1:0];
            CSR_REPLACEMENT_BYTES:  rep_bytes_in = csr_wdata;
            CSR_REPLACEMENT_LENGTH: rep_len_in   = csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      pend_buf_in  = pend_buf_ff;
      pend_cnt_in  = pend_cnt_ff;
      line_last_in = line_last_ff;
      rep_idx_in   = rep_idx_ff;
      if (cmd.accept) begin
         pend_buf_in[wr_idx] = req_data.text_byte;
         pend_cnt_in         = CNT_W'(wr_idx) + CNT_W'(1);
         line_last_in        = req_data.line_end;
      end
      if (cmd.emit_pending) begin
         for (int k = 0; k < BUF_DEPTH - 1; k++) begin
            pend_buf_in[k] = pend_buf_ff[k+1];
         end
         pend_cnt_in = pend_cnt_ff - CNT_W'(1);
      end
      if (cmd.start_repl) begin
         pend_cnt_in = '0;
         rep_idx_in  = '0;
      end
      if (cmd.emit_repl) begin
         rep_idx_in = rep_idx_ff + IDX_W'(1);
      end
      if (pat_write) begin
         pend_cnt_in = '0;
      end
   end

   // staging holds the newest emitted byte until we know if it is the last one
   always_comb begin
      stage_byte_in  = stage_byte_ff;
      stage_valid_in = stage_valid_ff;
      out_in         = out_ff;
      out_valid_in   = out_valid_ff;
      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (push) begin
         out_in.out_byte = stage_byte_ff;
         out_in.run_last = cmd.finish;
         out_valid_in    = 1'b1;
      end
      if (emit) begin
         stage_byte_in  = emit_byte;
         stage_valid_in = 1'b1;
      end else if (cmd.finish) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_bytes_ff   <= '0;
         pat_len_ff     <= LEN_W'(1);
         rep_bytes_ff   <= '0;
         rep_len_ff     <= '0;
         pend_cnt_ff    <= '0;
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         pat_bytes_ff   <= pat_bytes_in;
         pat_len_ff     <= pat_len_in;
         rep_bytes_ff   <= rep_bytes_in;
         rep_len_ff     <= rep_len_in;
         pend_cnt_ff    <= pend_cnt_in;
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_buf_ff   <= pend_buf_in;
      line_last_ff  <= line_last_in;
      rep_idx_ff    <= rep_idx_in;
      stage_byte_ff <= stage_byte_in;
      out_ff        <= out_in;
   end

   assign rsp_data  = out_ff;
   assign rsp_valid = out_valid_ff;

   assign status.prefix_ok   = prefix_ok;
   assign status.full_match  = prefix_ok && (pend_cnt_ff >= plen);
   assign status.pend_empty  = (pend_cnt_ff == '0);
   assign status.pend_one    = (pend_cnt_ff == CNT_W'(1));
   assign status.repl_none   = (rlen == '0);
   assign status.repl_done   = ({1'b0, rep_idx_ff} == (rlen - LEN_W'(1)));
   assign status.line_last   = line_last_ff;
   assign status.stage_valid = stage_valid_ff;
   assign status.emit_ok     = !stage_valid_ff || slot_free;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      pend_cnt_ff <= CNT_W'(BUF_DEPTH))
      else $error("pending count above buffer depth");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> slot_free)
      else $error("output register overwritten while stalled");

   a_repl_range: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_repl |-> ({1'b0, rep_idx_ff} < rlen))
      else $error("replacement index past replacement length");

endmodule

// File: rtl/core/ssr_ctrl.sv
// ----------------------------------------------------------------------------
// ssr_ctrl
// Sequencer: accept a word, recheck the pending prefix, emit literals,
// replacement or line flush, then close the run.
// ----------------------------------------------------------------------------
module ssr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output ssr_pkg::cmd_type     cmd,
   input  ssr_pkg::status_type  status
);
   import ssr_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CHECK  = 3'd1;
   localparam logic [2:0] S_REPL   = 3'd2;
   localparam logic [2:0] S_FLUSH  = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [2:0] done_state;

   // close the run only if a word is staged
   assign done_state = status.stage_valid ? S_FINISH : S_IDLE;
   assign req_ready  = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_CHECK;
            end
         end
         S_CHECK: begin
            if (!status.prefix_ok) begin
               // oldest pending byte can no longer start a match
               if (status.emit_ok) begin
                  cmd.emit_pending = 1'b1;
               end
            end else if (status.full_match) begin
               cmd.start_repl = 1'b1;
               state_in       = status.repl_none ? done_state : S_REPL;
            end else if (status.line_last && !status.pend_empty) begin
               state_in = S_FLUSH;
            end else begin
               state_in = done_state;
            end
         end
         S_REPL: begin
            if (status.emit_ok) begin
               cmd.emit_repl = 1'b1;
               if (status.repl_done) begin
                  state_in = S_FINISH;
               end
            end
         end
         S_FLUSH: begin
            if (status.emit_ok) begin
               cmd.emit_pending = 1'b1;
               if (status.pend_one) begin
                  state_in = S_FINISH;
               end
            end
         end
         S_FINISH: begin
            if (status.emit_ok) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !status.stage_valid)
      else $error("idle with a staged word left behind");

   a_accept_check: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_CHECK))
      else $error("accepted word not checked next cycle");

   a_flush_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FLUSH) |-> !status.pend_empty)
      else $error("flush with empty pending buffer");

endmodule

// File: rtl/core/stream_substring_replace_core.sv
// ----------------------------------------------------------------------------
// stream_substring_replace_core
// Line-oriented find-and-replace over a byte stream.
//
// req_* takes one text byte per word with a line_end flag on the last byte
// of each line. rsp_* returns the rewritten bytes; run_last marks the final
// word caused by one input word (an input may cause none). csr_* writes the
// pattern and replacement registers; a pattern write drops pending bytes.
// Configure only while idle.
// An input word is accepted, then its pending prefix is checked; a word that
// is only held in the pending buffer yields no result word. Otherwise the
// sequencer emits one byte per cycle into a staging register while the
// output is not stalled, then closes the run. Output stalls stop the
// sequencer; the next input word is taken once the run is closed, even if
// the output register still holds an untaken word. A result word passes
// through the staging register and then the output register.
// Reset clears the pending count, restores default registers and empties
// the output register.
// ----------------------------------------------------------------------------
module stream_substring_replace_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  ssr_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output ssr_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic [ssr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ssr_pkg::TEXT_W-1:0]    csr_wdata
);
   import ssr_pkg::*;

   cmd_type    cmd;
   status_type status;

   ssr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .status    (status)
   );

   ssr_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status)
   );

endmodule
